### rtl/mrd_pkg.sv
// shared types and constants for the modbus rtu response deframer
package mrd_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam int          FUNC_EXC_BIT   = 7;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam int          TDATA_W        = 104;
  localparam int          TUSER_W        = 3;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_FUNC   = 3'd1,
    PH_EXC    = 3'd2,
    PH_COUNT  = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_WORD = 3'd0,
    EV_OK   = 3'd1,
    EV_EXC  = 3'd2,
    EV_CRC  = 3'd3,
    EV_ODD  = 3'd4,
    EV_DROP = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_kind;
    logic [7:0]  slave_address;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [6:0]  word_count;
    logic [31:0] float_bits;
    logic        float_valid;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } result_t;

endpackage

### rtl/mrd_crc16.sv
// one-byte update of the reflected crc-16 used by modbus rtu
module mrd_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

### rtl/mrd_parser.sv
// frame state, crc accumulator and event generation for one byte per cycle while step is high
module mrd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output mrd_pkg::result_t res
);

  mrd_pkg::phase_t phase, phase_next;
  logic [7:0]  slave_hold, slave_hold_next;
  logic        func_exc, func_exc_next;
  logic [7:0]  data_byte_total, data_byte_total_next;
  logic [7:0]  data_bytes_seen, data_bytes_seen_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [15:0] first_word_hold, first_word_hold_next;
  logic [15:0] second_word_hold, second_word_hold_next;
  logic [7:0]  crc_low_hold, crc_low_hold_next;
  logic [7:0]  exception_hold, exception_hold_next;
  logic [6:0]  words_seen, words_seen_next;

  logic        restart;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;

  mrd_crc16 u_crc (
    .crc_in  (crc_in),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  // a new frame starts on an address byte or on a dropped function byte
  always_comb begin
    restart = 1'b0;
    case (phase)
      mrd_pkg::PH_ADDR: restart = 1'b1;
      mrd_pkg::PH_FUNC: restart = !rx_byte[mrd_pkg::FUNC_EXC_BIT] &&
                                  (rx_byte != mrd_pkg::FUNC_READ_HOLD);
      mrd_pkg::PH_EXC, mrd_pkg::PH_COUNT, mrd_pkg::PH_DATA,
      mrd_pkg::PH_CRC_LO, mrd_pkg::PH_CRC_HI: restart = 1'b0;
      default: restart = 1'b1;
    endcase
    crc_in = restart ? mrd_pkg::CRC_INIT : crc_accum;
  end

  always_comb begin
    logic [7:0]  seen_inc;
    logic [15:0] w;
    logic [15:0] rx_crc;
    seen_inc = data_bytes_seen + 8'd1;
    w        = {high_byte_hold, rx_byte};
    rx_crc   = {rx_byte, crc_low_hold};

    phase_next            = phase;
    slave_hold_next       = slave_hold;
    func_exc_next         = func_exc;
    data_byte_total_next  = data_byte_total;
    data_bytes_seen_next  = data_bytes_seen;
    crc_accum_next        = crc_accum;
    high_byte_hold_next   = high_byte_hold;
    first_word_hold_next  = first_word_hold;
    second_word_hold_next = second_word_hold;
    crc_low_hold_next     = crc_low_hold;
    exception_hold_next   = exception_hold;
    words_seen_next       = words_seen;
    res_valid             = 1'b0;
    res                   = '0;

    case (phase)
      mrd_pkg::PH_FUNC: begin
        if (!restart) begin
          func_exc_next  = rx_byte[mrd_pkg::FUNC_EXC_BIT];
          crc_accum_next = crc_upd;
          phase_next     = rx_byte[mrd_pkg::FUNC_EXC_BIT] ? mrd_pkg::PH_EXC
                                                          : mrd_pkg::PH_COUNT;
        end else begin
          res_valid         = 1'b1;
          res.event_kind    = mrd_pkg::EV_DROP;
          res.slave_address = slave_hold;
          res.word_value    = {8'h00, rx_byte};
        end
      end
      mrd_pkg::PH_EXC: begin
        exception_hold_next = rx_byte;
        crc_accum_next      = crc_upd;
        phase_next          = mrd_pkg::PH_CRC_LO;
      end
      mrd_pkg::PH_COUNT: begin
        data_byte_total_next = rx_byte;
        data_bytes_seen_next = 8'd0;
        words_seen_next      = 7'd0;
        crc_accum_next       = crc_upd;
        phase_next           = (rx_byte == 8'd0) ? mrd_pkg::PH_CRC_LO : mrd_pkg::PH_DATA;
      end
      mrd_pkg::PH_DATA: begin
        crc_accum_next       = crc_upd;
        data_bytes_seen_next = seen_inc;
        if (seen_inc[0]) begin
          high_byte_hold_next = rx_byte;
        end else begin
          res_valid         = 1'b1;
          res.event_kind    = mrd_pkg::EV_WORD;
          res.slave_address = slave_hold;
          res.word_value    = w;
          res.word_index    = words_seen;
          if (words_seen == 7'd0) begin
            first_word_hold_next = w;
          end else if (words_seen == 7'd1) begin
            second_word_hold_next = w;
          end
          words_seen_next = words_seen + 7'd1;
        end
        if (seen_inc == data_byte_total) begin
          phase_next = mrd_pkg::PH_CRC_LO;
        end
      end
      mrd_pkg::PH_CRC_LO: begin
        crc_low_hold_next = rx_byte;
        phase_next        = mrd_pkg::PH_CRC_HI;
      end
      mrd_pkg::PH_CRC_HI: begin
        res_valid         = 1'b1;
        res.slave_address = slave_hold;
        res.word_count    = words_seen;
        res.received_crc  = rx_crc;
        res.computed_crc  = crc_accum;
        if (rx_crc != crc_accum) begin
          res.event_kind = mrd_pkg::EV_CRC;
        end else if (func_exc) begin
          res.event_kind = mrd_pkg::EV_EXC;
          res.word_value = {8'h00, exception_hold};
        end else if (data_byte_total[0]) begin
          res.event_kind = mrd_pkg::EV_ODD;
        end else begin
          res.event_kind = mrd_pkg::EV_OK;
          if (words_seen == 7'd2) begin
            res.float_bits  = {first_word_hold, second_word_hold};
            res.float_valid = 1'b1;
          end
        end
        phase_next     = mrd_pkg::PH_ADDR;
        crc_accum_next = mrd_pkg::CRC_INIT;
      end
      default: begin
      end
    endcase

    // start of a new frame from this byte
    if (restart) begin
      slave_hold_next       = rx_byte;
      crc_accum_next        = crc_upd;
      func_exc_next         = 1'b0;
      data_byte_total_next  = 8'd0;
      data_bytes_seen_next  = 8'd0;
      high_byte_hold_next   = 8'd0;
      first_word_hold_next  = 16'd0;
      second_word_hold_next = 16'd0;
      exception_hold_next   = 8'd0;
      words_seen_next       = 7'd0;
      phase_next            = mrd_pkg::PH_FUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= mrd_pkg::PH_ADDR;
      slave_hold       <= 8'd0;
      func_exc         <= 1'b0;
      data_byte_total  <= 8'd0;
      data_bytes_seen  <= 8'd0;
      crc_accum        <= mrd_pkg::CRC_INIT;
      high_byte_hold   <= 8'd0;
      first_word_hold  <= 16'd0;
      second_word_hold <= 16'd0;
      crc_low_hold     <= 8'd0;
      exception_hold   <= 8'd0;
      words_seen       <= 7'd0;
    end else if (step) begin
      phase            <= phase_next;
      slave_hold       <= slave_hold_next;
      func_exc         <= func_exc_next;
      data_byte_total  <= data_byte_total_next;
      data_bytes_seen  <= data_bytes_seen_next;
      crc_accum        <= crc_accum_next;
      high_byte_hold   <= high_byte_hold_next;
      first_word_hold  <= first_word_hold_next;
      second_word_hold <= second_word_hold_next;
      crc_low_hold     <= crc_low_hold_next;
      exception_hold   <= exception_hold_next;
      words_seen       <= words_seen_next;
    end
  end

endmodule

### rtl/modbus_rtu_response_deframer_unit.sv
// top level of the modbus rtu response deframer with input and result registers
// Takes one received byte per beat and frames read-holding-register and
// exception responses, giving at most one event beat per byte. A byte is
// accepted every cycle while results are taken; a byte waits in the input
// register and its event is registered into the result register when the
// byte steps the parser. The rate is set by the combinational frame state
// update, which includes an eight-step crc-16 byte update. A stalled
// result only holds back bytes that would produce another event.
module modbus_rtu_response_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // slave_address, word_value, word_index, word_count, float_bits,
  // float_valid, received_crc, computed_crc, zero pad
  output logic [mrd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [mrd_pkg::TUSER_W-1:0] m_axis_tuser   // event_kind
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             res_valid;
  mrd_pkg::result_t res;
  logic             advance;
  logic             out_valid;
  mrd_pkg::result_t out_res;

  mrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance       = in_valid && (!res_valid || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.event_kind;
  assign m_axis_tdata  = {1'b0,
                          out_res.computed_crc,
                          out_res.received_crc,
                          out_res.float_valid,
                          out_res.float_bits,
                          out_res.word_count,
                          out_res.word_index,
                          out_res.word_value,
                          out_res.slave_address};

  // a held result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !(advance && res_valid))
    else $error("result register overwritten while stalled");

  // an event produced by the parser shows up in the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> out_valid)
    else $error("parser event lost");

  // an accepted byte always lands in the input register
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> in_valid)
    else $error("accepted byte lost");

  // float pattern only on an ok frame
  a_float_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.float_valid |-> out_res.event_kind == mrd_pkg::EV_OK)
    else $error("float pattern on a frame that is not ok");

endmodule
